### rtl/core/cca_pkg.sv
// cca_pkg: shared constants and register codes of the circle coverage block
// no dependencies; imported by every module under rtl/core
`default_nettype none

package cca_pkg;

  // radius register width in bits
  localparam int unsigned RADIUS_BITS = 11;

  // width of the configuration register index
  localparam int unsigned CFG_IDX_BITS = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_RADIUS   = 2'd2
  } cfg_reg_e;

endpackage

`default_nettype wire

### rtl/core/cca_offset.sv
// cca_offset: center differences, scaled radius, per-sample offset magnitudes
// two register stages; depends on cca_pkg
`default_nettype none

module cca_offset #(
  parameter int unsigned SAMPLES_PER_AXIS = 8,
  parameter int unsigned COORD_BITS       = 16,
  parameter int unsigned MAG_W            = 21,
  parameter int unsigned LIMIT_W          = 30
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire logic [COORD_BITS-1:0]                  px_i,
  input  wire logic [COORD_BITS-1:0]                  py_i,
  input  wire logic [COORD_BITS-1:0]                  cx_i,
  input  wire logic [COORD_BITS-1:0]                  cy_i,
  input  wire logic [cca_pkg::RADIUS_BITS-1:0]        radius_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic [COORD_BITS-1:0]                       out_px_o,
  output logic [COORD_BITS-1:0]                       out_py_o,
  output logic [SAMPLES_PER_AXIS-1:0][MAG_W-1:0]      mag_x_o,
  output logic [SAMPLES_PER_AXIS-1:0][MAG_W-1:0]      mag_y_o,
  output logic [LIMIT_W-1:0]                          limit_o
);
  import cca_pkg::*;

  localparam int unsigned SCALE = 2 * SAMPLES_PER_AXIS;
  localparam int unsigned SB    = $clog2(SCALE);
  localparam int unsigned DW    = COORD_BITS + 1;
  localparam int unsigned UW    = MAG_W + 1;
  localparam int unsigned RW    = RADIUS_BITS + SB;
  localparam logic signed [UW-1:0] SCALE_S = UW'(SCALE);

  // stage 1 registers
  logic                   v1_q;
  logic signed [DW-1:0]   dx_d, dy_d, dx_q, dy_q;
  logic [RW-1:0]          rs_d, rs_q;
  logic [COORD_BITS-1:0]  px1_q, py1_q;

  // stage 2 registers
  logic                                   v2_q;
  logic [SAMPLES_PER_AXIS-1:0][MAG_W-1:0] mag_x_d, mag_y_d, mag_x_q, mag_y_q;
  logic [LIMIT_W-1:0]                     limit_d, limit_q;
  logic [COORD_BITS-1:0]                  px2_q, py2_q;

  logic en1, en2;
  logic signed [UW-1:0] bx, by;

  // stage advance: a stage moves when it is empty or its successor moves
  assign en2        = !v2_q || out_ready_i;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  // differences at full precision, radius in sample units
  assign dx_d = signed'({px_i[COORD_BITS-1], px_i}) - signed'({cx_i[COORD_BITS-1], cx_i});
  assign dy_d = signed'({py_i[COORD_BITS-1], py_i}) - signed'({cy_i[COORD_BITS-1], cy_i});
  assign rs_d = RW'(radius_i) * RW'(SCALE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      rs_q  <= rs_d;
      px1_q <= px_i;
      py1_q <= py_i;
    end
  end

  // sample positions: difference times scale plus odd sub-pixel offset
  assign bx = UW'(dx_q) * SCALE_S;
  assign by = UW'(dy_q) * SCALE_S;

  for (genvar g = 0; g < SAMPLES_PER_AXIS; g++) begin : g_lane
    logic signed [UW-1:0] ux, uy;
    assign ux         = bx + UW'(2 * g + 1);
    assign uy         = by + UW'(2 * g + 1);
    assign mag_x_d[g] = ux[UW-1] ? MAG_W'(-ux) : MAG_W'(ux);
    assign mag_y_d[g] = uy[UW-1] ? MAG_W'(-uy) : MAG_W'(uy);
  end

  // squared radius in sample units
  assign limit_d = LIMIT_W'(rs_q) * LIMIT_W'(rs_q);

  always_ff @(posedge clk_i) begin
    if (en2) begin
      mag_x_q <= mag_x_d;
      mag_y_q <= mag_y_d;
      limit_q <= limit_d;
      px2_q   <= px1_q;
      py2_q   <= py1_q;
    end
  end

  assign out_valid_o = v2_q;
  assign out_px_o    = px2_q;
  assign out_py_o    = py2_q;
  assign mag_x_o     = mag_x_q;
  assign mag_y_o     = mag_y_q;
  assign limit_o     = limit_q;

endmodule

`default_nettype wire

### rtl/core/cca_square.sv
// cca_square: one squarer per sample column and per sample row
// one register stage; depends on cca_pkg
`default_nettype none

module cca_square #(
  parameter int unsigned SAMPLES_PER_AXIS = 8,
  parameter int unsigned COORD_BITS       = 16,
  parameter int unsigned MAG_W            = 21,
  parameter int unsigned SQ_W             = 42,
  parameter int unsigned LIMIT_W          = 30
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic [COORD_BITS-1:0]                 px_i,
  input  wire logic [COORD_BITS-1:0]                 py_i,
  input  wire logic [SAMPLES_PER_AXIS-1:0][MAG_W-1:0] mag_x_i,
  input  wire logic [SAMPLES_PER_AXIS-1:0][MAG_W-1:0] mag_y_i,
  input  wire logic [LIMIT_W-1:0]                    limit_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic [COORD_BITS-1:0]                      out_px_o,
  output logic [COORD_BITS-1:0]                      out_py_o,
  output logic [SAMPLES_PER_AXIS-1:0][SQ_W-1:0]      sq_x_o,
  output logic [SAMPLES_PER_AXIS-1:0][SQ_W-1:0]      sq_y_o,
  output logic [LIMIT_W-1:0]                         limit_o
);
  import cca_pkg::*;

  logic                                  v3_q;
  logic                                  en3;
  logic [SAMPLES_PER_AXIS-1:0][SQ_W-1:0] sq_x_d, sq_y_d, sq_x_q, sq_y_q;
  logic [LIMIT_W-1:0]                    limit_q;
  logic [COORD_BITS-1:0]                 px3_q, py3_q;

  assign en3        = !v3_q || out_ready_i;
  assign in_ready_o = en3;

  // squared offset per column and per row
  for (genvar g = 0; g < SAMPLES_PER_AXIS; g++) begin : g_sq
    assign sq_x_d[g] = SQ_W'(mag_x_i[g]) * SQ_W'(mag_x_i[g]);
    assign sq_y_d[g] = SQ_W'(mag_y_i[g]) * SQ_W'(mag_y_i[g]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      sq_x_q  <= sq_x_d;
      sq_y_q  <= sq_y_d;
      limit_q <= limit_i;
      px3_q   <= px_i;
      py3_q   <= py_i;
    end
  end

  assign out_valid_o = v3_q;
  assign out_px_o    = px3_q;
  assign out_py_o    = py3_q;
  assign sq_x_o      = sq_x_q;
  assign sq_y_o      = sq_y_q;
  assign limit_o     = limit_q;

endmodule

`default_nettype wire

### rtl/core/cca_cover.sv
// cca_cover: sample hit test, coverage count, alpha lookup and output register
// four register stages; depends on cca_pkg
`default_nettype none

module cca_cover #(
  parameter int unsigned SAMPLES_PER_AXIS = 8,
  parameter int unsigned COORD_BITS       = 16,
  parameter int unsigned SQ_W             = 42,
  parameter int unsigned LIMIT_W          = 30
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic [COORD_BITS-1:0]                 px_i,
  input  wire logic [COORD_BITS-1:0]                 py_i,
  input  wire logic [SAMPLES_PER_AXIS-1:0][SQ_W-1:0] sq_x_i,
  input  wire logic [SAMPLES_PER_AXIS-1:0][SQ_W-1:0] sq_y_i,
  input  wire logic [LIMIT_W-1:0]                    limit_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic [COORD_BITS-1:0]                      out_px_o,
  output logic [COORD_BITS-1:0]                      out_py_o,
  output logic [7:0]                                 alpha_o
);
  import cca_pkg::*;

  localparam int unsigned N     = SAMPLES_PER_AXIS;
  localparam int unsigned TOTAL = SAMPLES_PER_AXIS * SAMPLES_PER_AXIS;
  localparam int unsigned CMPW  = (SQ_W + 1 > LIMIT_W) ? SQ_W + 1 : LIMIT_W;
  localparam int unsigned RCW   = $clog2(SAMPLES_PER_AXIS + 1);
  localparam int unsigned CNTW  = $clog2(TOTAL + 1);

  logic en4, en5, en6, en7;

  // stage 4: hit mask
  logic                  v4_q;
  logic [TOTAL-1:0]      hit_d, hit_q;
  logic [COORD_BITS-1:0] px4_q, py4_q;

  // stage 5: per-row counts
  logic                          v5_q;
  logic [N-1:0][RCW-1:0]         rc_d, rc_q;
  logic [COORD_BITS-1:0]         px5_q, py5_q;

  // stage 6: total count
  logic                  v6_q;
  logic [CNTW-1:0]       cnt_d, cnt_q;
  logic [COORD_BITS-1:0] px6_q, py6_q;

  // stage 7: output register
  logic                  v7_d, v7_q;
  logic [7:0]            alpha_q;
  logic [COORD_BITS-1:0] px7_q, py7_q;

  logic [7:0] alpha_lut [TOTAL+1];

  // stage advance; a pixel with no covered sample leaves stage 6 unconditionally
  assign en7        = !v7_q || out_ready_i;
  assign en6        = !v6_q || en7 || (cnt_q == '0);
  assign en5        = !v5_q || en6;
  assign en4        = !v4_q || en5;
  assign in_ready_o = en4;
  assign v7_d       = en7 ? (v6_q && (cnt_q != '0)) : v7_q;

  // sample inside when squared distance does not exceed squared radius
  for (genvar gy = 0; gy < N; gy++) begin : g_row
    for (genvar gx = 0; gx < N; gx++) begin : g_col
      assign hit_d[gy*N + gx] =
        (CMPW'(sq_x_i[gx]) + CMPW'(sq_y_i[gy])) <= CMPW'(limit_i);
    end
    assign rc_d[gy] = RCW'($countones(hit_q[gy*N +: N]));
  end

  // sum of row counts
  always_comb begin
    cnt_d = '0;
    for (int i = 0; i < N; i++) begin
      cnt_d = cnt_d + CNTW'(rc_q[i]);
    end
  end

  // rounded coverage table, fixed at elaboration
  for (genvar c = 0; c <= TOTAL; c++) begin : g_lut
    assign alpha_lut[c] = 8'((c * 255 + TOTAL / 2) / TOTAL);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      if (en4) v4_q <= in_valid_i;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
      v7_q <= v7_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      hit_q <= hit_d;
      px4_q <= px_i;
      py4_q <= py_i;
    end
    if (en5) begin
      rc_q  <= rc_d;
      px5_q <= px4_q;
      py5_q <= py4_q;
    end
    if (en6) begin
      cnt_q <= cnt_d;
      px6_q <= px5_q;
      py6_q <= py5_q;
    end
    if (en7) begin
      alpha_q <= alpha_lut[cnt_q];
      px7_q   <= px6_q;
      py7_q   <= py6_q;
    end
  end

  assign out_valid_o = v7_q;
  assign out_px_o    = px7_q;
  assign out_py_o    = py7_q;
  assign alpha_o     = alpha_q;

  // a delivered pixel always has some coverage
  a_alpha_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v7_q |-> alpha_q != 8'd0)
    else $error("cca_cover: result with zero alpha");

  // count never exceeds the sample total
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v6_q |-> cnt_q <= CNTW'(TOTAL))
    else $error("cca_cover: coverage count out of range");

  // an item moving out of the row stage arrives in the count stage
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q && en5 |=> v6_q)
    else $error("cca_cover: item lost between row and count stage");

  // a stalled result keeps its alpha
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v7_q && !out_ready_i |=> v7_q && $stable(alpha_q))
    else $error("cca_cover: stalled result changed");

endmodule

`default_nettype wire

### rtl/core/circle_coverage_alpha.sv
// circle_coverage_alpha: supersampled anti-aliased coverage of a filled circle
// depends on cca_pkg, cca_offset, cca_square and cca_cover
//
// usage:
//   configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while
//   the stream is idle: center x, center y and radius in pixels (radius 0
//   draws nothing). all three reset to zero.
//   each request on the slave stream carries one pixel coordinate. the pixel
//   is sampled on a SAMPLES_PER_AXIS square grid; the result, sent on the
//   master stream only when at least one sample falls inside the circle,
//   carries the coordinate and alpha = rounded covered fraction times 255.
//   pixels with no covered sample produce no result.
// timing:
//   seven register stages: offsets, sample magnitudes, squares, hit mask,
//   row counts, total count, output register. one pixel is taken every cycle
//   while a receiver stall has not filled the pipeline.
//   when the receiver stalls, each stage holds its item and the bubbles in
//   front of it fill; s_axis_tready_o drops only once every stage is full.
//   reset empties the pipeline.
`default_nettype none

module circle_coverage_alpha #(
  parameter int unsigned SAMPLES_PER_AXIS = 8,
  parameter int unsigned COORD_BITS       = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration write port
  input  wire logic                               cfg_we_i,
  input  wire logic [cca_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  wire logic [((COORD_BITS > cca_pkg::RADIUS_BITS) ?
                      COORD_BITS : cca_pkg::RADIUS_BITS)-1:0] cfg_data_i,
  // pixel requests
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // tdata: pixel_x, pixel_y, zero padding
  input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]  s_axis_tdata_i,
  // coverage results
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // tdata: out_x, out_y, coverage_alpha, zero padding
  output logic [((2*COORD_BITS+15)/8)*8-1:0]      m_axis_tdata_o
);
  import cca_pkg::*;

  localparam int unsigned SCALE   = 2 * SAMPLES_PER_AXIS;
  localparam int unsigned SB      = $clog2(SCALE);
  localparam int unsigned MAG_W   = COORD_BITS + SB + 1;
  localparam int unsigned SQ_W    = 2 * MAG_W;
  localparam int unsigned LIMIT_W = 2 * (RADIUS_BITS + SB);

  // configuration registers
  logic [COORD_BITS-1:0]  cx_d, cx_q, cy_d, cy_q;
  logic [RADIUS_BITS-1:0] r_d, r_q;

  always_comb begin
    cx_d = cx_q;
    cy_d = cy_q;
    r_d  = r_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_CENTER_X: cx_d = cfg_data_i[COORD_BITS-1:0];
        CFG_CENTER_Y: cy_d = cfg_data_i[COORD_BITS-1:0];
        CFG_RADIUS:   r_d  = cfg_data_i[RADIUS_BITS-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
      r_q  <= '0;
    end else begin
      cx_q <= cx_d;
      cy_q <= cy_d;
      r_q  <= r_d;
    end
  end

  // inter-module links
  logic                                   off_valid, off_ready;
  logic [COORD_BITS-1:0]                  off_px, off_py;
  logic [SAMPLES_PER_AXIS-1:0][MAG_W-1:0] off_mag_x, off_mag_y;
  logic [LIMIT_W-1:0]                     off_limit;

  logic                                   sq_valid, sq_ready;
  logic [COORD_BITS-1:0]                  sq_px, sq_py;
  logic [SAMPLES_PER_AXIS-1:0][SQ_W-1:0]  sq_x, sq_y;
  logic [LIMIT_W-1:0]                     sq_limit;

  logic [COORD_BITS-1:0]                  res_px, res_py;
  logic [7:0]                             res_alpha;

  // offsets and sample magnitudes
  cca_offset #(
    .SAMPLES_PER_AXIS (SAMPLES_PER_AXIS),
    .COORD_BITS       (COORD_BITS),
    .MAG_W            (MAG_W),
    .LIMIT_W          (LIMIT_W)
  ) u_offset (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .px_i        (s_axis_tdata_i[COORD_BITS-1:0]),
    .py_i        (s_axis_tdata_i[2*COORD_BITS-1:COORD_BITS]),
    .cx_i        (cx_q),
    .cy_i        (cy_q),
    .radius_i    (r_q),
    .out_valid_o (off_valid),
    .out_ready_i (off_ready),
    .out_px_o    (off_px),
    .out_py_o    (off_py),
    .mag_x_o     (off_mag_x),
    .mag_y_o     (off_mag_y),
    .limit_o     (off_limit)
  );

  // squarers
  cca_square #(
    .SAMPLES_PER_AXIS (SAMPLES_PER_AXIS),
    .COORD_BITS       (COORD_BITS),
    .MAG_W            (MAG_W),
    .SQ_W             (SQ_W),
    .LIMIT_W          (LIMIT_W)
  ) u_square (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (off_valid),
    .in_ready_o  (off_ready),
    .px_i        (off_px),
    .py_i        (off_py),
    .mag_x_i     (off_mag_x),
    .mag_y_i     (off_mag_y),
    .limit_i     (off_limit),
    .out_valid_o (sq_valid),
    .out_ready_i (sq_ready),
    .out_px_o    (sq_px),
    .out_py_o    (sq_py),
    .sq_x_o      (sq_x),
    .sq_y_o      (sq_y),
    .limit_o     (sq_limit)
  );

  // hit test, count and alpha
  cca_cover #(
    .SAMPLES_PER_AXIS (SAMPLES_PER_AXIS),
    .COORD_BITS       (COORD_BITS),
    .SQ_W             (SQ_W),
    .LIMIT_W          (LIMIT_W)
  ) u_cover (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sq_valid),
    .in_ready_o  (sq_ready),
    .px_i        (sq_px),
    .py_i        (sq_py),
    .sq_x_i      (sq_x),
    .sq_y_i      (sq_y),
    .limit_i     (sq_limit),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_px_o    (res_px),
    .out_py_o    (res_py),
    .alpha_o     (res_alpha)
  );

  // result packing
  always_comb begin
    m_axis_tdata_o                                    = '0;
    m_axis_tdata_o[COORD_BITS-1:0]                    = res_px;
    m_axis_tdata_o[2*COORD_BITS-1:COORD_BITS]         = res_py;
    m_axis_tdata_o[2*COORD_BITS+7:2*COORD_BITS]       = res_alpha;
  end

endmodule

`default_nettype wire

### dv/cca_checker.sv
// cca_checker: watches the config port and both streams of circle_coverage_alpha,
// predicts each pixel's coverage result and compares it with what the block sends
// depends on cca_pkg for the register index codes
`timescale 1ns / 1ps

module cca_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cca_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [15:0]                      cfg_data_i,
  input  logic                             s_tvalid_i,
  input  logic                             s_tready_i,
  // tdata: pixel_x, pixel_y
  input  logic [31:0]                      s_tdata_i,
  input  logic                             m_tvalid_i,
  input  logic                             m_tready_i,
  // tdata: out_x, out_y, coverage_alpha
  input  logic [39:0]                      m_tdata_i,
  output int unsigned                      fail_count_o,
  output int unsigned                      pending_o
);
  import cca_pkg::*;

  localparam int GRID  = 8;
  localparam int SUB   = 2 * GRID;
  localparam int TOTAL = GRID * GRID;

  typedef struct packed {
    logic [7:0]  alpha;
    logic [15:0] y;
    logic [15:0] x;
  } pixel_cov_t;

  // circle registers as the block should hold them
  logic signed [15:0] circ_cx;
  logic signed [15:0] circ_cy;
  logic [RADIUS_BITS-1:0] circ_r;

  pixel_cov_t  coverage_q[$];
  pixel_cov_t  want;
  pixel_cov_t  got;
  int unsigned hits;
  int unsigned errs;

  // number of sub-pixel samples of one pixel inside the circle
  function automatic int unsigned covered_samples(logic signed [15:0] px,
                                                  logic signed [15:0] py,
                                                  logic signed [15:0] cx,
                                                  logic signed [15:0] cy,
                                                  logic [RADIUS_BITS-1:0] r);
    longint lim;
    longint bx;
    longint by;
    longint ex;
    longint ey;
    int unsigned n;
    n = 0;
    if (r == 0) return 0;
    // positions in 1/16 pixel units, sample offsets are odd
    lim = longint'(r) * longint'(r) * SUB * SUB;
    bx  = (longint'(px) - longint'(cx)) * SUB;
    by  = (longint'(py) - longint'(cy)) * SUB;
    for (int sy = 0; sy < GRID; sy++) begin
      ey = by + 2 * sy + 1;
      for (int sx = 0; sx < GRID; sx++) begin
        ex = bx + 2 * sx + 1;
        if (ex * ex + ey * ey <= lim) n++;
      end
    end
    return n;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      circ_cx = '0;
      circ_cy = '0;
      circ_r  = '0;
      coverage_q.delete();
      errs = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // register writes, unknown index ignored
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CENTER_X: circ_cx = cfg_data_i;
          CFG_CENTER_Y: circ_cy = cfg_data_i;
          CFG_RADIUS:   circ_r  = cfg_data_i[RADIUS_BITS-1:0];
          default: ;
        endcase
      end
      // result side first so a same-cycle request cannot match itself
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i;
        if (coverage_q.size() == 0) begin
          if (errs < 10)
            $display("[%0t] unexpected result x=%0d y=%0d alpha=%0d", $realtime,
                     $signed(got.x), $signed(got.y), got.alpha);
          errs++;
        end else begin
          want = coverage_q.pop_front();
          if (got !== want) begin
            if (errs < 10)
              $display("[%0t] mismatch exp x=%0d y=%0d alpha=%0d got x=%0d y=%0d alpha=%0d",
                       $realtime, $signed(want.x), $signed(want.y), want.alpha,
                       $signed(got.x), $signed(got.y), got.alpha);
            errs++;
          end
        end
      end
      // pixel request side
      if (s_tvalid_i && s_tready_i) begin
        hits = covered_samples(s_tdata_i[15:0], s_tdata_i[31:16], circ_cx, circ_cy, circ_r);
        if (hits > 0) begin
          want.x     = s_tdata_i[15:0];
          want.y     = s_tdata_i[31:16];
          want.alpha = 8'((hits * 255 + TOTAL / 2) / TOTAL);
          coverage_q.push_back(want);
        end
      end
      fail_count_o <= errs;
      pending_o    <= coverage_q.size();
    end
  end

endmodule

### dv/tb_top.sv
// tb_top: pixel stream and register stimulus for circle_coverage_alpha
// depends on cca_pkg, the block under rtl/core and cca_checker
`timescale 1ns / 1ps

module tb_top;
  import cca_pkg::*;

  localparam int unsigned LIMIT = 200000;
  localparam int          DRAIN_CYCLES = 20;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_idx;
  logic [15:0]             cfg_data;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [31:0]             s_tdata;
  logic                    m_tvalid;
  logic                    m_tready;
  logic [39:0]             m_tdata;
  int unsigned             fail_count;
  int unsigned             pending;
  int unsigned             cycles = 0;
  bit                      idle_on;

  circle_coverage_alpha dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  cca_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    m_tready <= !(idle_on && $urandom_range(0, 99) < 12);
  end

  // one pixel request, held until taken
  task automatic send_pixel(input logic [15:0] x, input logic [15:0] y);
    while (idle_on && $urandom_range(0, 99) < 12) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // stop requests and let every pixel in flight leave the pipeline
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // new circle while idle; the unused index gets a write that must be ignored
  task automatic program_circle(input logic [15:0] cx, input logic [15:0] cy,
                                input logic [15:0] rdata);
    logic [15:0] junk;
    junk = 16'($urandom);
    drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_UNUSED;
    cfg_data <= junk;
    @(posedge clk);
    cfg_idx  <= CFG_CENTER_X;
    cfg_data <= cx;
    @(posedge clk);
    cfg_idx  <= CFG_CENTER_Y;
    cfg_data <= cy;
    @(posedge clk);
    cfg_idx  <= CFG_RADIUS;
    cfg_data <= rdata;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // random circle, then pixels mostly around it and some anywhere
  task automatic run_phase(input int n_items);
    logic [15:0] cx;
    logic [15:0] cy;
    logic [10:0] r;
    logic [4:0]  top;
    logic [15:0] px;
    logic [15:0] py;
    int          span;
    cx  = 16'($urandom);
    cy  = 16'($urandom);
    top = 5'($urandom);
    case ($urandom_range(0, 9))
      0:       r = '0;
      1:       r = 11'd2047;
      2:       r = 11'($urandom);
      default: r = 11'($urandom_range(1, 24));
    endcase
    program_circle(cx, cy, {top, r});
    span = int'(r) + 2;
    repeat (n_items) begin
      if ($urandom_range(0, 99) < 85) begin
        px = cx + 16'($urandom_range(0, 2 * span) - span);
        py = cy + 16'($urandom_range(0, 2 * span) - span);
      end else begin
        px = 16'($urandom);
        py = 16'($urandom);
      end
      send_pixel(px, py);
    end
  endtask

  initial begin
    rst_n    <= 1'b0;
    cfg_we   <= 1'b0;
    cfg_idx  <= CFG_CENTER_X;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    idle_on  = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero radius after reset: nothing comes back
    send_pixel(16'sd0, 16'sd0);
    send_pixel(16'h8000, 16'h7fff);
    send_pixel(16'h7fff, 16'h8000);

    // unit circle at the origin: partial pixels and misses
    program_circle(16'd0, 16'd0, 16'd1);
    send_pixel(16'd0, 16'd0);
    send_pixel(16'hffff, 16'hffff);
    send_pixel(16'd0, 16'hffff);
    send_pixel(16'hffff, 16'd0);
    send_pixel(16'd1, 16'd0);
    send_pixel(16'hfffe, 16'd0);

    // largest radius in a corner, high data bits must not reach the radius
    program_circle(16'h7fff, 16'h8000, 16'hffff);
    send_pixel(16'h7fff, 16'h8000);
    send_pixel(16'h8000, 16'h7fff);
    send_pixel(16'h7fff - 16'd2047, 16'h8000);
    send_pixel(16'h7fff - 16'd1448, 16'h8000 + 16'd1448);
    send_pixel(16'h7fff - 16'd2048, 16'h8000);

    // small circle in the opposite corner, far pixels must not wrap around
    program_circle(16'h8000, 16'h7fff, 16'ha803);
    send_pixel(16'h8000, 16'h7fff);
    send_pixel(16'h8002, 16'h7ffd);
    send_pixel(16'h8003, 16'h7fff);
    send_pixel(16'h7fff, 16'h8000);
    send_pixel(16'h5555, 16'haaaa);

    // random phases, two of them without any idling
    for (int ph = 0; ph < 10; ph++) begin
      idle_on = !(ph == 3 || ph == 4);
      run_phase(55);
    end
    idle_on = 1'b1;

    drain();
    @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/cca_pkg.sv
rtl/core/cca_offset.sv
rtl/core/cca_square.sv
rtl/core/cca_cover.sv
rtl/core/circle_coverage_alpha.sv
dv/cca_checker.sv
dv/tb_top.sv
